>>> design/elcc_pkg.sv
// Shared types, constants and calendar helper functions for the calendar clock.
`default_nettype none

package elcc_pkg;

  localparam int T_W = 33;

  localparam logic [31:0]    NTP_UNIX_OFFSET = 32'd2208988800;
  localparam logic [T_W-1:0] SEC_LEAP_YEAR   = 33'd31622400;
  localparam logic [T_W-1:0] SEC_YEAR        = 33'd31536000;
  localparam logic [T_W-1:0] SEC_DAY         = 33'd86400;
  localparam logic [T_W-1:0] SEC_HOUR        = 33'd3600;
  localparam logic [T_W-1:0] SEC_MIN         = 33'd60;

  localparam logic [11:0] YEAR_BASE   = 12'd1970;
  localparam logic [11:0] YEAR_MAX    = 12'd4095;
  localparam logic [8:0]  YEAR400_BASE = 9'd370;   // 1970 mod 400
  localparam logic [2:0]  WDAY_BASE   = 3'd3;      // 1970-01-01 was a Thursday

  typedef enum logic [1:0] {
    DIV_DAY  = 2'd0,
    DIV_HOUR = 2'd1,
    DIV_MIN  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     tick;
    logic     load_init;
    logic     year_step;
    logic     month_step;
    logic     div_step;
    div_sel_t div_sel;
    logic [2:0] shift;
    logic     out_load;
    logic     out_rej;
  } elcc_cmd_t;

  typedef struct packed {
    logic ntp_zero;
    logic year_fit;
    logic month_fit;
  } elcc_sts_t;

  function automatic logic leap_of(input logic [8:0] yr400);
    return (yr400[1:0] == 2'd0) && (yr400 != 9'd100) && (yr400 != 9'd200) &&
           (yr400 != 9'd300);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [T_W-1:0] month_secs(input logic [4:0] d);
    logic [T_W-1:0] s;
    case (d)
      5'd28:   s = 33'd2419200;
      5'd29:   s = 33'd2505600;
      5'd30:   s = 33'd2592000;
      default: s = 33'd2678400;
    endcase
    return s;
  endfunction

  // weekday + a, modulo 7, for a below 7
  function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [2:0] a);
    logic [3:0] s;
    s = {1'b0, w} + {1'b0, a};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // 2^k mod 7, for k below 7
  function automatic logic [2:0] pow2_mod7(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd4;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd2;
      3'd5:    r = 3'd4;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/elcc_dp.sv
// Datapath: calendar state, tick carry logic, load walk and restoring divide steps.
`default_nettype none

module elcc_dp import elcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] ntp_seconds,
  input  wire logic        cfg_we,
  input  wire logic        cfg_winter,
  input  wire elcc_cmd_t   cmd,
  output elcc_sts_t        sts,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [2:0]       weekday,
  output logic             rejected
);

  logic [11:0]    cur_year;
  logic [3:0]     cur_month;
  logic [4:0]     cur_day;
  logic [4:0]     cur_hour;
  logic [5:0]     cur_minute;
  logic [5:0]     cur_second;
  logic [8:0]     yr400;
  logic [2:0]     wday;
  logic           winter;
  logic [T_W-1:0] t;

  logic           leap_cur;
  logic [4:0]     mdays;
  logic [T_W-1:0] year_len;
  logic [T_W-1:0] mon_len;
  logic [T_W-1:0] dsor;
  logic           div_ge;
  logic [T_W-1:0] t_rem;
  logic [T_W-1:0] t_load;
  logic [8:0]     yr400_inc;

  // tick carries
  logic sat, sec_c, min_c, hr_c, day_c, mon_c;

  assign leap_cur  = leap_of(yr400);
  assign mdays     = month_days(cur_month, leap_cur);
  assign year_len  = leap_cur ? SEC_LEAP_YEAR : SEC_YEAR;
  assign mon_len   = month_secs(mdays);
  assign yr400_inc = (yr400 == 9'd399) ? 9'd0 : yr400 + 9'd1;

  assign t_load = {1'b0, ntp_seconds - NTP_UNIX_OFFSET} + (winter ? SEC_HOUR : '0);

  always_comb begin
    case (cmd.div_sel)
      DIV_DAY:  dsor = SEC_DAY << cmd.shift;
      DIV_HOUR: dsor = SEC_HOUR << cmd.shift;
      DIV_MIN:  dsor = SEC_MIN << cmd.shift;
      default:  dsor = SEC_DAY << cmd.shift;
    endcase
  end

  assign div_ge = (t >= dsor);
  assign t_rem  = div_ge ? (t - dsor) : t;

  assign sts.ntp_zero  = (ntp_seconds == 32'd0);
  assign sts.year_fit  = (t < year_len);
  assign sts.month_fit = (cur_month >= 4'd12) || (t < mon_len);

  assign sat   = (cur_year == YEAR_MAX) && (cur_month == 4'd12) && (cur_day == 5'd31) &&
                 (cur_hour == 5'd23) && (cur_minute == 6'd59) && (cur_second == 6'd59);
  assign sec_c = (cur_second == 6'd59);
  assign min_c = sec_c && (cur_minute == 6'd59);
  assign hr_c  = min_c && (cur_hour == 5'd23);
  assign day_c = hr_c && (cur_day == mdays);
  assign mon_c = day_c && (cur_month == 4'd12);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year   <= YEAR_BASE;
      cur_month  <= 4'd1;
      cur_day    <= 5'd1;
      cur_hour   <= 5'd0;
      cur_minute <= 6'd0;
      cur_second <= 6'd0;
      yr400      <= YEAR400_BASE;
      wday       <= WDAY_BASE;
      winter     <= 1'b0;
    end else begin
      if (cfg_we) begin
        winter <= cfg_winter;
      end
      if (cmd.tick && !sat) begin
        cur_second <= sec_c ? 6'd0 : cur_second + 6'd1;
        if (sec_c) begin
          cur_minute <= min_c ? 6'd0 : cur_minute + 6'd1;
        end
        if (min_c) begin
          cur_hour <= hr_c ? 5'd0 : cur_hour + 5'd1;
        end
        if (hr_c) begin
          cur_day <= day_c ? 5'd1 : cur_day + 5'd1;
          wday    <= wday_add(wday, 3'd1);
        end
        if (day_c) begin
          cur_month <= mon_c ? 4'd1 : cur_month + 4'd1;
        end
        if (mon_c && (cur_year != YEAR_MAX)) begin
          cur_year <= cur_year + 12'd1;
          yr400    <= yr400_inc;
        end
      end
      if (cmd.load_init) begin
        cur_year   <= YEAR_BASE;
        yr400      <= YEAR400_BASE;
        cur_month  <= 4'd1;
        cur_day    <= 5'd1;
        cur_hour   <= 5'd0;
        cur_minute <= 6'd0;
        cur_second <= 6'd0;
        wday       <= WDAY_BASE;
      end
      if (cmd.year_step && !sts.year_fit) begin
        cur_year <= cur_year + 12'd1;
        yr400    <= yr400_inc;
        wday     <= wday_add(wday, leap_cur ? 3'd2 : 3'd1);
      end
      if (cmd.month_step && !sts.month_fit) begin
        cur_month <= cur_month + 4'd1;
        wday      <= wday_add(wday, 3'(mdays - 5'd28));
      end
      if (cmd.div_step) begin
        case (cmd.div_sel)
          DIV_DAY: begin
            if (div_ge) begin
              cur_day <= cur_day + (5'd1 << cmd.shift);
              wday    <= wday_add(wday, pow2_mod7(cmd.shift));
            end
          end
          DIV_HOUR: begin
            if (div_ge) begin
              cur_hour <= cur_hour + (5'd1 << cmd.shift);
            end
          end
          DIV_MIN: begin
            if (div_ge) begin
              cur_minute <= cur_minute + (6'd1 << cmd.shift);
            end
            cur_second <= t_rem[5:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // working seconds count and result register
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      t <= t_load;
    end else if (cmd.year_step && !sts.year_fit) begin
      t <= t - year_len;
    end else if (cmd.month_step && !sts.month_fit) begin
      t <= t - mon_len;
    end else if (cmd.div_step) begin
      t <= t_rem;
    end
    if (cmd.out_load) begin
      year     <= cur_year;
      month    <= cur_month;
      day      <= cur_day;
      hour     <= cur_hour;
      minute   <= cur_minute;
      second   <= cur_second;
      weekday  <= wday;
      rejected <= cmd.out_rej;
    end
  end

endmodule

`default_nettype wire

>>> design/elcc_ctrl.sv
// Controller: sequences tick, load walk and divide steps, and owns both handshakes.
`default_nettype none

module elcc_ctrl import elcc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      mode,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire elcc_sts_t sts,
  output elcc_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_YEAR  = 7'b0000010,
    S_MONTH = 7'b0000100,
    S_DAY   = 7'b0001000,
    S_HOUR  = 7'b0010000,
    S_MIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       rej;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.div_sel = DIV_DAY;
    cmd.shift   = cnt;
    cmd.out_rej = rej;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!mode) begin
            cmd.tick   = 1'b1;
            state_next = S_OUT;
          end else if (sts.ntp_zero) begin
            state_next = S_OUT;
          end else begin
            cmd.load_init = 1'b1;
            state_next    = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        cmd.year_step = 1'b1;
        if (sts.year_fit) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_fit) begin
          state_next = S_DAY;
          cnt_next   = 3'd4;
        end
      end
      S_DAY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_DAY;
        if (cnt == 3'd0) begin
          state_next = S_HOUR;
          cnt_next   = 3'd4;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      S_HOUR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_HOUR;
        if (cnt == 3'd0) begin
          state_next = S_MIN;
          cnt_next   = 3'd5;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      S_MIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_MIN;
        if (cnt == 3'd0) begin
          state_next = S_OUT;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      S_OUT: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 3'd0;
      rej       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) begin
        rej <= mode && sts.ntp_zero;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/epoch_load_calendar_clock.sv
// Calendar clock with one-second ticks and NTP timestamp loads.
// Tick or rejected load: no walk; the output state registers the result.
// Load: one-step-per-cycle walk over Y whole years since 1970 (up to ~136) and M
//   whole months (up to 11), then the day, hour and minute divider, then output.
// One item in flight; the next transaction is taken once the result is registered.
// Synchronous reset sets 1970-01-01 00:00:00 (Thursday) and clears the stored winter offset.
`default_nettype none

module epoch_load_calendar_clock import elcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        winter_offset,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [31:0] ntp_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [2:0]       weekday,
  output logic             rejected
);

  elcc_cmd_t cmd;
  elcc_sts_t sts;

  assign cfg_ready = 1'b1;

  elcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  elcc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ntp_seconds (ntp_seconds),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_winter  (winter_offset),
    .cmd         (cmd),
    .sts         (sts),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .weekday     (weekday),
    .rejected    (rejected)
  );

endmodule

`default_nettype wire

>>> tb/epoch_load_calendar_clock_tb.sv
// Self-checking testbench for the calendar clock: ticks and NTP loads against a date predictor.
`timescale 1ns / 100ps

module epoch_load_calendar_clock_tb;

  localparam bit        OP_TICK       = 1'b0;
  localparam bit        OP_LOAD       = 1'b1;
  localparam bit [31:0] NTP_EPOCH_GAP = 32'd2208988800;
  localparam int        CYCLE_LIMIT   = 1_000_000;
  localparam int        SETTLE_CYCLES = 200;

  typedef struct packed {
    bit        mode;
    bit [31:0] ntp;
  } clock_cmd_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        rejected;
  } clock_reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        winter_offset = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = OP_TICK;
  logic [31:0] ntp_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic        rejected;

  // predicted clock state and register copy
  int unsigned cal_year = 1970, cal_month = 1, cal_day = 1;
  int unsigned cal_hour = 0, cal_minute = 0, cal_second = 0;
  bit          winter_mode = 1'b0;

  clock_cmd_t     cmd_backlog[$];
  clock_reading_t pending_dates[$];

  bit cmd_taken = 1'b0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int cycles = 0;
  int error_count = 0;
  int n_loads = 0, n_zero_loads = 0, n_ticks = 0, n_checked = 0, n_cfg_writes = 0;

  epoch_load_calendar_clock i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .winter_offset (winter_offset),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .ntp_seconds   (ntp_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .weekday       (weekday),
    .rejected      (rejected)
  );

  always #10 clk = ~clk;

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 31;
    endcase
  endfunction

  // Zeller, with +5J so the sum never goes negative; 0 = Monday
  function automatic int unsigned zeller_weekday(int unsigned y, int unsigned m,
                                                 int unsigned d);
    int unsigned k, j, h;
    if (m < 3) begin
      m = m + 12;
      y = y - 1;
    end
    k = y % 100;
    j = y / 100;
    h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 5) % 7;
  endfunction

  function automatic void set_from_unix(longint unsigned t);
    int unsigned y, m;
    longint unsigned span;
    y = 1970;
    m = 1;
    span = leap_year(y) ? 31622400 : 31536000;
    while (t >= span) begin
      t -= span;
      y++;
      span = leap_year(y) ? 31622400 : 31536000;
    end
    span = days_in_month(y, m) * 86400;
    while (m < 12 && t >= span) begin
      t -= span;
      m++;
      span = days_in_month(y, m) * 86400;
    end
    cal_year   = y;
    cal_month  = m;
    cal_day    = int'(t / 86400) + 1;
    t          = t % 86400;
    cal_hour   = int'(t / 3600);
    t          = t % 3600;
    cal_minute = int'(t / 60);
    cal_second = int'(t % 60);
  endfunction

  function automatic void advance_second();
    // last second of year 4095 holds
    if (cal_year >= 4095 && cal_month >= 12 && cal_day >= 31 &&
        cal_hour >= 23 && cal_minute >= 59 && cal_second >= 59)
      return;
    cal_second++;
    if (cal_second >= 60) begin
      cal_second = 0;
      cal_minute++;
    end
    if (cal_minute >= 60) begin
      cal_minute = 0;
      cal_hour++;
    end
    if (cal_hour >= 24) begin
      cal_hour = 0;
      cal_day++;
    end
    if (cal_day > days_in_month(cal_year, cal_month)) begin
      cal_day = 1;
      cal_month++;
    end
    if (cal_month > 12) begin
      cal_month = 1;
      if (cal_year < 4095) cal_year++;
    end
  endfunction

  function automatic clock_reading_t calendar_after(clock_cmd_t c);
    clock_reading_t r;
    bit [31:0] unix32;
    longint unsigned t;
    r.rejected = 1'b0;
    if (c.mode == OP_LOAD) begin
      if (c.ntp == 32'd0) begin
        r.rejected = 1'b1;
      end else begin
        unix32 = c.ntp - NTP_EPOCH_GAP;  // wraps past 2036
        t = unix32;
        if (winter_mode) t += 3600;
        set_from_unix(t);
      end
    end else begin
      advance_second();
    end
    r.year    = 12'(cal_year);
    r.month   = 4'(cal_month);
    r.day     = 5'(cal_day);
    r.hour    = 5'(cal_hour);
    r.minute  = 6'(cal_minute);
    r.second  = 6'(cal_second);
    r.weekday = 3'(zeller_weekday(cal_year, cal_month, cal_day));
    return r;
  endfunction

  function automatic string show(clock_reading_t r);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd=%0d rej=%0d", r.year, r.month, r.day,
                     r.hour, r.minute, r.second, r.weekday, r.rejected);
  endfunction

  function automatic bit [31:0] ntp_at(int unsigned y, int unsigned m, int unsigned d,
                                       int unsigned h, int unsigned mi, int unsigned s);
    longint unsigned u;
    int unsigned yy, mm;
    u = 0;
    for (yy = 1970; yy < y; yy++) u += leap_year(yy) ? 31622400 : 31536000;
    for (mm = 1; mm < m; mm++) u += days_in_month(y, mm) * 86400;
    u += (d - 1) * 86400 + h * 3600 + mi * 60 + s;
    return 32'(u + NTP_EPOCH_GAP);
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_cmd(bit m, bit [31:0] n);
    clock_cmd_t c;
    c.mode = m;
    c.ntp  = n;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random(int n);
    int made, r, y, m, k;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_cmd(OP_TICK, $urandom);
        made++;
      end else if (r < 65) begin
        // land just before a month end, then tick toward it, at times across it
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0:       y = 1972;
            1:       y = 2000;
            2:       y = 2096;
            3:       y = 2100;
            default: y = 2104;
          endcase
        end else begin
          y = $urandom_range(1970, 2105);
        end
        m = $urandom_range(1, 12);
        push_cmd(OP_LOAD, ntp_at(y, m, days_in_month(y, m), $urandom_range(22, 23), 59,
                                 $urandom_range(50, 59)));
        k = $urandom_range(1, 12);
        repeat (k) push_cmd(OP_TICK, $urandom);
        made += k + 1;
      end else if (r < 93) begin
        push_cmd(OP_LOAD, $urandom);
        made++;
      end else begin
        push_cmd(OP_LOAD, 32'd0);
        made++;
      end
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || pending_dates.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_winter(bit val);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    winter_offset <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int done, chunk;
    done = 0;
    while (done < n) begin
      chunk = (n - done < 100) ? (n - done) : 100;
      calm = ($urandom_range(0, 3) == 0);
      queue_random(chunk);
      drain();
      done += chunk;
    end
  endtask

  // input driver
  always @(negedge clk) begin : drive_in
    clock_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || cmd_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        in_valid    <= 1'b1;
        mode        <= nxt.mode;
        ntp_seconds <= nxt.ntp;
        in_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall = idle_len();
    end
  end

  always @(posedge clk) begin : watch
    clock_cmd_t seen;
    clock_reading_t got, want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        winter_mode = winter_offset;
        n_cfg_writes++;
      end
      if (in_valid && in_ready) begin
        seen.mode = mode;
        seen.ntp  = ntp_seconds;
        pending_dates.push_back(calendar_after(seen));
        if (seen.mode == OP_LOAD) begin
          n_loads++;
          if (seen.ntp == 32'd0) n_zero_loads++;
        end else begin
          n_ticks++;
        end
      end
      if (out_valid && out_ready) begin
        got = {year, month, day, hour, minute, second, weekday, rejected};
        if (pending_dates.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: result with no transaction pending: %s", show(got));
        end else begin
          want = pending_dates.pop_front();
          n_checked++;
          if (got !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR: result %0d expected %s got %s", n_checked, show(want),
                       show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("epoch_load_calendar_clock verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // winter mode off (reset value)
    calm = 1'b0;
    push_cmd(OP_TICK, 32'hFFFF_FFFF);
    push_cmd(OP_LOAD, 32'd0);
    push_cmd(OP_LOAD, 32'd1);
    push_cmd(OP_LOAD, 32'hFFFF_FFFF);
    push_cmd(OP_LOAD, NTP_EPOCH_GAP);
    push_cmd(OP_LOAD, NTP_EPOCH_GAP - 32'd1);
    push_cmd(OP_LOAD, ntp_at(1999, 12, 31, 23, 59, 59));
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_LOAD, ntp_at(2000, 2, 28, 23, 59, 59));
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_LOAD, ntp_at(2000, 2, 29, 23, 59, 59));
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_LOAD, ntp_at(2100, 2, 28, 23, 59, 59));
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_LOAD, ntp_at(2024, 4, 30, 23, 59, 58));
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_LOAD, 32'd0);
    drain();
    random_phase(250);

    // winter hour on: carries out of the day, month and year, and past 32 bits
    write_winter(1'b1);
    push_cmd(OP_LOAD, NTP_EPOCH_GAP);
    push_cmd(OP_LOAD, NTP_EPOCH_GAP - 32'd1);
    push_cmd(OP_LOAD, ntp_at(2020, 12, 31, 23, 30, 0));
    push_cmd(OP_LOAD, ntp_at(2104, 2, 28, 23, 0, 0));
    push_cmd(OP_TICK, 32'd0);
    push_cmd(OP_LOAD, 32'd0);
    drain();
    random_phase(250);

    write_winter(1'b0);
    random_phase(150);
    write_winter(1'b1);
    random_phase(150);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d ticks and %0d loads (%0d with a zero timestamp) over %0d register writes",
             n_ticks, n_loads, n_zero_loads, n_cfg_writes);
    $display("%0d results checked, %0d mismatches", n_checked, error_count);
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("epoch_load_calendar_clock verification clean");
    end else begin
      $display("epoch_load_calendar_clock verification failed");
    end
    $finish;
  end

endmodule
